// ----- rtl/sled_pkg.sv -----
// Shared types and constants for the status LED pattern sequencer.
// No dependencies; used by status_led_pattern_sequencer_top.
package sled_pkg;

	// Widths fixed by the interface
	localparam int MS_WIDTH      = 16;
	localparam int CMD_WIDTH     = 3;
	localparam int VALUE_WIDTH   = 2;
	localparam int CFG_IDX_WIDTH = 3;

	// Default countdown width
	localparam int TIME_WIDTH_DEFAULT = 16;

	// Command codes carried by each input item
	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_TICK       = 3'd0,
		CMD_SET_ENABLE = 3'd1,
		CMD_SET_LINK   = 3'd2,
		CMD_SET_ANN    = 3'd3,
		CMD_SET_HB     = 3'd4,
		CMD_ACTIVITY   = 3'd5
	} cmd_t;

	// Connection states
	localparam logic [VALUE_WIDTH-1:0] LINK_DISCONNECTED = 2'd0;
	localparam logic [VALUE_WIDTH-1:0] LINK_CONNECTING   = 2'd1;
	localparam logic [VALUE_WIDTH-1:0] LINK_CONNECTED    = 2'd2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_HB_ON    = 3'd0,
		REG_HB_OFF   = 3'd1,
		REG_ANN_ON   = 3'd2,
		REG_ANN_OFF  = 3'd3,
		REG_CONN_ON  = 3'd4,
		REG_CONN_OFF = 3'd5,
		REG_ACT_BLNK = 3'd6
	} reg_idx_t;

	// Register reset values in milliseconds
	localparam logic [MS_WIDTH-1:0] HB_ON_RST    = 16'd30;
	localparam logic [MS_WIDTH-1:0] HB_OFF_RST   = 16'd2000;
	localparam logic [MS_WIDTH-1:0] ANN_ON_RST   = 16'd100;
	localparam logic [MS_WIDTH-1:0] ANN_OFF_RST  = 16'd100;
	localparam logic [MS_WIDTH-1:0] CONN_ON_RST  = 16'd30;
	localparam logic [MS_WIDTH-1:0] CONN_OFF_RST = 16'd400;
	localparam logic [MS_WIDTH-1:0] ACT_BLNK_RST = 16'd30;

endpackage

// ----- rtl/status_led_pattern_sequencer_top.sv -----
// Status LED pattern sequencer: input register, registered state update, LED/timer result.
// Depends on sled_pkg.
//
//  channel | signals                                   | direction | handshake
//  --------+-------------------------------------------+-----------+-------------------------
//  in      | in_valid, in_stall, cmd, value            | sink      | valid & !stall
//  out     | out_valid, out_stall, led_lit,            | source    | valid & !stall
//          | timer_active, remaining_ms                |           |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | sink      | valid & ready (always ready)
//
// An item is captured in the input register and then evaluated into the state and
// result registers; one item is taken per cycle while the output is not stalled.
// The state registers double as the result register and hold while out_valid and
// out_stall are both high; the input register still takes one more item during that stall.
// Reset clears all mode state and loads the register defaults; no clearing pass.
module status_led_pattern_sequencer_top #(
	parameter int TIME_WIDTH = sled_pkg::TIME_WIDTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item input
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [sled_pkg::CMD_WIDTH-1:0]       cmd,
	input  logic [sled_pkg::VALUE_WIDTH-1:0]     value,
	// result output
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 led_lit,
	output logic                                 timer_active,
	output logic [sled_pkg::MS_WIDTH-1:0]        remaining_ms,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sled_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [sled_pkg::MS_WIDTH-1:0]        cfg_data
);

	localparam int MW = sled_pkg::MS_WIDTH;
	localparam int CW = (TIME_WIDTH > MW) ? TIME_WIDTH : MW;
	localparam logic [CW-1:0] TIME_MAX_W = CW'({TIME_WIDTH{1'b1}});

	// configuration registers
	logic [MW-1:0] hb_on_q, hb_off_q, ann_on_q, ann_off_q;
	logic [MW-1:0] conn_on_q, conn_off_q, act_blink_q;

	// input register
	logic                              valid_s1;
	sled_pkg::cmd_t                    cmd_s1;
	logic [sled_pkg::VALUE_WIDTH-1:0]  value_s1;

	// mode state
	logic                              enabled_q, announce_q, heartbeat_q, activity_q;
	logic [sled_pkg::VALUE_WIDTH-1:0]  link_q;
	logic                              phase_q, timer_q, led_q, carry_q;
	logic [TIME_WIDTH-1:0]             countdown_q;
	logic                              out_valid_q;

	// next-state values
	logic                              enabled_d, announce_d, heartbeat_d, activity_d;
	logic [sled_pkg::VALUE_WIDTH-1:0]  link_d;
	logic                              phase_d, timer_d, led_d, carry_d;
	logic [TIME_WIDTH-1:0]             countdown_d;

	logic advance;
	logic in_accept;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_on_q     <= sled_pkg::HB_ON_RST;
			hb_off_q    <= sled_pkg::HB_OFF_RST;
			ann_on_q    <= sled_pkg::ANN_ON_RST;
			ann_off_q   <= sled_pkg::ANN_OFF_RST;
			conn_on_q   <= sled_pkg::CONN_ON_RST;
			conn_off_q  <= sled_pkg::CONN_OFF_RST;
			act_blink_q <= sled_pkg::ACT_BLNK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (sled_pkg::reg_idx_t'(cfg_index))
				sled_pkg::REG_HB_ON:    hb_on_q     <= cfg_data;
				sled_pkg::REG_HB_OFF:   hb_off_q    <= cfg_data;
				sled_pkg::REG_ANN_ON:   ann_on_q    <= cfg_data;
				sled_pkg::REG_ANN_OFF:  ann_off_q   <= cfg_data;
				sled_pkg::REG_CONN_ON:  conn_on_q   <= cfg_data;
				sled_pkg::REG_CONN_OFF: conn_off_q  <= cfg_data;
				sled_pkg::REG_ACT_BLNK: act_blink_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1   <= sled_pkg::cmd_t'(cmd);
			value_s1 <= value;
		end
	end

	// apply command, then evaluate pattern if triggered
	always_comb begin
		logic                  flag;
		logic                  do_eval;
		logic                  disabled;
		logic [MW-1:0]         delay;
		logic [TIME_WIDTH-1:0] cd_dec;
		logic [CW-1:0]         delay_w;

		flag        = (value_s1 != '0);
		do_eval     = 1'b0;
		enabled_d   = enabled_q;
		announce_d  = announce_q;
		heartbeat_d = heartbeat_q;
		activity_d  = activity_q;
		link_d      = link_q;
		phase_d     = phase_q;
		timer_d     = timer_q;
		led_d       = led_q;
		carry_d     = carry_q;
		countdown_d = countdown_q;
		cd_dec      = (countdown_q == '0) ? '0 : countdown_q - TIME_WIDTH'(1);
		delay       = '0;
		delay_w     = '0;

		// command phase
		unique case (cmd_s1)
			sled_pkg::CMD_TICK: begin
				if (timer_q) begin
					countdown_d = cd_dec;
					if (cd_dec == '0) begin
						timer_d = 1'b0;
						do_eval = 1'b1;
					end
				end
			end
			sled_pkg::CMD_SET_ENABLE: begin
				enabled_d = flag;
				do_eval   = 1'b1;
			end
			sled_pkg::CMD_SET_LINK: begin
				if (value_s1 <= sled_pkg::LINK_CONNECTED) begin
					link_d  = value_s1;
					do_eval = enabled_q;
				end
			end
			sled_pkg::CMD_SET_ANN: begin
				announce_d = flag;
				do_eval    = enabled_q;
			end
			sled_pkg::CMD_SET_HB: begin
				heartbeat_d = flag;
				do_eval     = enabled_q;
			end
			sled_pkg::CMD_ACTIVITY: begin
				activity_d = 1'b1;
				do_eval    = enabled_q;
			end
			default: ;
		endcase

		// evaluation phase: pick mode in priority order
		disabled = !enabled_d;
		if (do_eval) begin
			if (announce_d) begin
				delay = phase_d ? ann_off_q : ann_on_q;
			end else if (link_d == sled_pkg::LINK_DISCONNECTED) begin
				if (heartbeat_d) begin
					delay = phase_d ? hb_off_q : hb_on_q;
				end else begin
					phase_d = 1'b1;
				end
			end else if (link_d == sled_pkg::LINK_CONNECTING) begin
				delay = phase_d ? conn_off_q : conn_on_q;
			end else begin
				if (activity_d) begin
					led_d      = 1'b0;
					activity_d = 1'b0;
					carry_d    = 1'b1;
					delay      = act_blink_q;
				end else begin
					phase_d = 1'b0;
				end
			end

			// drive LED and phase
			priority if (disabled) begin
				led_d   = 1'b0;
				phase_d = 1'b0;
			end else if (carry_d) begin
				carry_d = 1'b0;
			end else begin
				led_d   = !phase_d;
				phase_d = !phase_d;
			end

			// rearm timer, saturating to countdown range, or stop it on a zero delay or when disabled
			delay_w = CW'(delay);
			if (delay == '0 || disabled) begin
				timer_d     = 1'b0;
				countdown_d = '0;
			end else begin
				timer_d     = 1'b1;
				countdown_d = TIME_WIDTH'((delay_w > TIME_MAX_W) ? TIME_MAX_W : delay_w);
			end
		end
	end

	// update state; state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q   <= 1'b0;
			announce_q  <= 1'b0;
			heartbeat_q <= 1'b0;
			activity_q  <= 1'b0;
			link_q      <= sled_pkg::LINK_DISCONNECTED;
			phase_q     <= 1'b0;
			timer_q     <= 1'b0;
			led_q       <= 1'b0;
			carry_q     <= 1'b0;
			countdown_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				enabled_q   <= enabled_d;
				announce_q  <= announce_d;
				heartbeat_q <= heartbeat_d;
				activity_q  <= activity_d;
				link_q      <= link_d;
				phase_q     <= phase_d;
				timer_q     <= timer_d;
				led_q       <= led_d;
				carry_q     <= carry_d;
				countdown_q <= countdown_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign led_lit      = led_q;
	assign timer_active = timer_q;
	assign remaining_ms = timer_q ? MW'(countdown_q) : '0;

	// a running timer always has time left
	assert property (@(posedge clk) disable iff (!arst_n) timer_q |-> (countdown_q != '0))
		else $error("timer running with zero countdown");

	// disabled means dark LED and idle timer
	assert property (@(posedge clk) disable iff (!arst_n) !enabled_q |-> (!led_q && !timer_q))
		else $error("LED or timer active while disabled");

	// an evaluated item always shows up as a result
	assert property (@(posedge clk) disable iff (!arst_n) advance |=> out_valid_q)
		else $error("evaluated item produced no result");

endmodule
